// ----- rtl/rba_pkg.sv -----
// ----------------------------------------------------------------------------
// rba_pkg
// Shared types and constants for the reference-counted block allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package rba_pkg;

   localparam int BLOCK_COUNT = 32;
   localparam int BLOCK_SIZE  = 64;

   localparam int IDX_W  = 5;
   localparam int MAP_W  = 2 ** IDX_W;
   localparam int CNT_W  = 6;
   localparam int RC_W   = 8;
   localparam int GEN_W  = 16;
   localparam int ADDR_W = 32;

   localparam logic [RC_W-1:0] RC_MAX = '1;
   localparam logic [MAP_W-1:0] MAP_RESET = MAP_W'((64'd1 << BLOCK_COUNT) - 64'd1);

   typedef enum logic [1:0] {
      CMD_ALLOC  = 2'd0,
      CMD_FREE   = 2'd1,
      CMD_ADDREF = 2'd2,
      CMD_NONE   = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      ST_OK       = 3'd0,
      ST_INVALID  = 3'd1,
      ST_FULL     = 3'd2,
      ST_STALE    = 3'd3,
      ST_OVERFLOW = 3'd4
   } status_type;

   typedef struct packed {
      cmd_type           cmd;
      logic [ADDR_W-1:0] handle_address;
      logic [IDX_W-1:0]  handle_index;
      logic [GEN_W-1:0]  handle_generation;
   } req_type;

   typedef struct packed {
      status_type        status;
      logic [ADDR_W-1:0] block_address;
      logic [IDX_W-1:0]  block_index;
      logic [GEN_W-1:0]  block_generation;
      logic              handle_cleared;
      logic [CNT_W-1:0]  free_blocks;
   } rsp_type;

   typedef struct packed {
      logic capture;
      logic lookup;
      logic commit;
   } ctl_type;

   typedef struct packed {
      logic out_free;
   } sts_type;

endpackage

`default_nettype wire

// ----- rtl/rba_ctrl.sv -----
// ----------------------------------------------------------------------------
// rba_ctrl
// Sequencer: capture request, look up block tables, commit and load result.
// ----------------------------------------------------------------------------
`default_nettype none

module rba_ctrl (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire rba_pkg::sts_type sts,
   output rba_pkg::ctl_type      ctl
);
   import rba_pkg::*;

   typedef enum logic [1:0] {
      S_IDLE,
      S_LOOKUP,
      S_EXEC
   } state_type;

   state_type state_ff;
   logic      ready_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         ready_ff <= 1'b1;
      end else begin
         case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  state_ff <= S_LOOKUP;
                  ready_ff <= 1'b0;
               end
            end
            S_LOOKUP: begin
               state_ff <= S_EXEC;
            end
            S_EXEC: begin
               if (sts.out_free) begin
                  state_ff <= S_IDLE;
                  ready_ff <= 1'b1;
               end
            end
            default: begin
               state_ff <= S_IDLE;
               ready_ff <= 1'b1;
            end
         endcase
      end
   end

   assign req_ready   = ready_ff;
   assign ctl.capture = req_valid && ready_ff;
   assign ctl.lookup  = (state_ff == S_LOOKUP);
   assign ctl.commit  = (state_ff == S_EXEC) && sts.out_free;

endmodule

`default_nettype wire

// ----- rtl/rba_datapath.sv -----
// ----------------------------------------------------------------------------
// rba_datapath
// Free map, block tables, handle check and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module rba_datapath (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire rba_pkg::ctl_type            ctl,
   output rba_pkg::sts_type                 sts,
   input  wire rba_pkg::req_type            req_payload,
   output logic                             rsp_valid,
   input  wire logic                        rsp_ready,
   output rba_pkg::rsp_type                 rsp_payload,
   input  wire logic                        csr_valid,
   input  wire logic [rba_pkg::ADDR_W-1:0]  csr_data
);
   import rba_pkg::*;

   logic [ADDR_W-1:0] pool_base_ff;
   logic [MAP_W-1:0]  free_map_ff;
   logic [CNT_W-1:0]  free_cnt_ff;
   logic [MAP_W-1:0]  vld_ff;

   logic [RC_W-1:0]   rc_mem  [MAP_W];
   logic [GEN_W-1:0]  gen_mem [MAP_W];

   req_type           req_ff;
   logic [IDX_W-1:0]  alloc_idx_ff;
   logic              empty_ff;
   logic              loc_ok_ff;
   logic [IDX_W-1:0]  blk_ff;
   logic [RC_W-1:0]   rc_rd_ff;
   logic [GEN_W-1:0]  gen_rd_ff;
   logic              vld_rd_ff;

   logic              rsp_valid_ff;
   rsp_type           rsp_ff;
   rsp_type           rsp_in;

   logic [IDX_W-1:0]  alloc_idx_in;
   logic [IDX_W-1:0]  rd_addr;
   logic [ADDR_W:0]   expect_addr;
   logic              loc_ok_in;
   logic [RC_W-1:0]   rc_cur;
   logic [GEN_W-1:0]  gen_cur;
   logic [RC_W-1:0]   rc_new;
   logic [GEN_W-1:0]  gen_new;
   logic              wr_en;
   logic              map_set;
   logic              map_clr;
   status_type        status;

   assign sts.out_free = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         pool_base_ff <= '0;
      end else if (csr_valid) begin
         pool_base_ff <= csr_data;
      end
   end

   // highest free block
   always_comb begin
      alloc_idx_in = '0;
      for (int i = 0; i < MAP_W; i++) begin
         if (free_map_ff[i]) begin
            alloc_idx_in = IDX_W'(i);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.capture) begin
         req_ff       <= req_payload;
         alloc_idx_ff <= alloc_idx_in;
         empty_ff     <= (free_map_ff == '0);
      end
   end

   // handle names a block iff its address is nonzero and equals base + index * size, no wrap
   assign expect_addr = {1'b0, pool_base_ff}
                      + (33'(req_ff.handle_index) * 33'(BLOCK_SIZE));
   assign loc_ok_in   = (req_ff.handle_address != '0)
                      && (6'(req_ff.handle_index) < 6'(BLOCK_COUNT))
                      && ({1'b0, req_ff.handle_address} == expect_addr);
   assign rd_addr     = (req_ff.cmd == CMD_ALLOC) ? alloc_idx_ff : req_ff.handle_index;

   always_ff @(posedge clock) begin
      if (ctl.lookup) begin
         loc_ok_ff <= loc_ok_in;
         blk_ff    <= rd_addr;
         rc_rd_ff  <= rc_mem[rd_addr];
         gen_rd_ff <= gen_mem[rd_addr];
         vld_rd_ff <= vld_ff[rd_addr];
      end
      if (wr_en) begin
         rc_mem[blk_ff]  <= rc_new;
         gen_mem[blk_ff] <= gen_new;
      end
   end

   assign rc_cur  = vld_rd_ff ? rc_rd_ff : '0;
   assign gen_cur = vld_rd_ff ? gen_rd_ff : '0;

   always_comb begin
      status  = ST_INVALID;
      rc_new  = rc_cur;
      gen_new = gen_cur;
      wr_en   = 1'b0;
      map_set = 1'b0;
      map_clr = 1'b0;
      rsp_in  = '0;
      case (req_ff.cmd)
         CMD_ALLOC: begin
            if (empty_ff) begin
               status = ST_FULL;
            end else begin
               status  = ST_OK;
               rc_new  = RC_W'(1);
               gen_new = gen_cur + GEN_W'(1);
               wr_en   = ctl.commit;
               map_clr = 1'b1;
               rsp_in.block_address    = pool_base_ff
                                       + (ADDR_W'(blk_ff) * ADDR_W'(BLOCK_SIZE));
               rsp_in.block_index      = blk_ff;
               rsp_in.block_generation = gen_new;
            end
         end
         CMD_FREE, CMD_ADDREF: begin
            if (!loc_ok_ff) begin
               status = ST_INVALID;
            end else if (gen_cur != req_ff.handle_generation) begin
               status = ST_STALE;
            end else if (free_map_ff[blk_ff]) begin
               status = ST_INVALID;
            end else if (req_ff.cmd == CMD_FREE) begin
               if (rc_cur == '0) begin
                  status = ST_INVALID;
               end else begin
                  status  = ST_OK;
                  rc_new  = rc_cur - RC_W'(1);
                  wr_en   = ctl.commit;
                  map_set = (rc_cur == RC_W'(1));
                  rsp_in.handle_cleared = 1'b1;
               end
            end else begin
               if (rc_cur == RC_MAX) begin
                  status = ST_OVERFLOW;
               end else begin
                  status = ST_OK;
                  rc_new = rc_cur + RC_W'(1);
                  wr_en  = ctl.commit;
               end
            end
         end
         default: begin
            status = ST_INVALID;
         end
      endcase
      rsp_in.status = status;
      if (map_set) begin
         rsp_in.free_blocks = free_cnt_ff + CNT_W'(1);
      end else if (map_clr) begin
         rsp_in.free_blocks = free_cnt_ff - CNT_W'(1);
      end else begin
         rsp_in.free_blocks = free_cnt_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         free_map_ff <= MAP_RESET;
         free_cnt_ff <= CNT_W'(BLOCK_COUNT);
         vld_ff      <= '0;
      end else if (ctl.commit) begin
         free_cnt_ff <= rsp_in.free_blocks;
         if (map_set) begin
            free_map_ff[blk_ff] <= 1'b1;
         end
         if (map_clr) begin
            free_map_ff[blk_ff] <= 1'b0;
         end
         if (wr_en) begin
            vld_ff[blk_ff] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (ctl.commit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.commit) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

`default_nettype wire

// ----- rtl/refcounted_block_allocator.sv -----
// ----------------------------------------------------------------------------
// refcounted_block_allocator
// Fixed-block pool allocator with reference counts and generation tags.
// ----------------------------------------------------------------------------
// One request is in flight at a time. The accepting edge captures it together
// with the highest-free-block search. The next edge reads the count and
// generation memories through their registered read port. The execute step then
// checks the handle, writes the tables back and loads the result. The result
// sits in an output register, so a request can be accepted while the previous
// result still waits. A waiting result holds the controller at the load step
// until it is taken. Tables read as zero after reset through per-block valid
// bits, so no clearing pass is needed. The pool base register may be written at
// any idle time and is always ready.
`default_nettype none

module refcounted_block_allocator (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   output logic                             req_ready,
   input  wire rba_pkg::req_type            req_payload,
   output logic                             rsp_valid,
   input  wire logic                        rsp_ready,
   output rba_pkg::rsp_type                 rsp_payload,
   input  wire logic                        csr_valid,
   output logic                             csr_ready,
   input  wire logic [rba_pkg::ADDR_W-1:0]  csr_data
);
   import rba_pkg::*;

   ctl_type ctl;
   sts_type sts;

   assign csr_ready = 1'b1;

   rba_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .ctl       (ctl)
   );

   rba_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .ctl         (ctl),
      .sts         (sts),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_data    (csr_data)
   );

endmodule

`default_nettype wire

// ----- rtl/rba_checker.sv -----
// ----------------------------------------------------------------------------
// rba_checker
// Port-level checks for the allocator, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module rba_checker (
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             req_valid,
   input wire logic             req_ready,
   input wire logic             rsp_valid,
   input wire logic             rsp_ready,
   input wire rba_pkg::rsp_type rsp_payload
);
   import rba_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped before taken");

   a_no_early_rsp: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && !rsp_valid |=> !rsp_valid)
      else $error("result too soon after request");

   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_payload.status != ST_OK) |->
         (rsp_payload.block_address == '0) && (rsp_payload.block_index == '0)
         && (rsp_payload.block_generation == '0) && !rsp_payload.handle_cleared)
      else $error("failed result carries block fields");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_payload.free_blocks <= CNT_W'(BLOCK_COUNT)))
      else $error("free count beyond pool size");

endmodule

bind refcounted_block_allocator rba_checker u_rba_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_valid),
   .req_ready   (req_ready),
   .rsp_valid   (rsp_valid),
   .rsp_ready   (rsp_ready),
   .rsp_payload (rsp_payload)
);

`default_nettype wire
